>>> rtl/crvg_pkg.sv
// Shared constants, types and tables for the cylinder ring vertex generator.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps
package crvg_pkg;

    localparam int MAX_MERIDIANS_DEF = 4096;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int RAD_W   = 16;
    localparam int POS_W   = 17;
    localparam int HH_W    = 15;
    localparam int VTX_W   = 13;
    localparam int TEX_W   = 16;
    localparam int PHASE_W = 32;
    localparam int ANG_W   = 34;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] PI_HALF_Q30     = 32'd1686629713;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam int          POS_LIMIT       = 65535;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    // Item handed from the front end to the back end through the queue.
    typedef struct packed {
        logic               bad;
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic [RAD_W-1:0]   radius;
        logic [HH_W-1:0]    half_h;
    } t_job;

    function automatic logic [31:0] atan_q30(input int k);
        logic [31:0] t;
        case (k)
            0:  t = 32'h3243F6A8;  1:  t = 32'h1DAC6705;
            2:  t = 32'h0FADBAFC;  3:  t = 32'h07F56EA6;
            4:  t = 32'h03FEAB76;  5:  t = 32'h01FFD55B;
            6:  t = 32'h00FFFAAA;  7:  t = 32'h007FFF55;
            8:  t = 32'h003FFFEA;  9:  t = 32'h001FFFFD;
            10: t = 32'h000FFFFF;  11: t = 32'h0007FFFF;
            12: t = 32'h0003FFFF;  13: t = 32'h0001FFFF;
            14: t = 32'h0000FFFF;  15: t = 32'h00007FFF;
            16: t = 32'h00003FFF;  17: t = 32'h00001FFF;
            18: t = 32'h00000FFF;  19: t = 32'h000007FF;
            20: t = 32'h000003FF;  21: t = 32'h000001FF;
            22: t = 32'h000000FF;  23: t = 32'h0000007F;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/cylinder_ring_vertex_generator_core.sv
// Cylinder ring vertex generator.
// One meridian index in, one ring point with vertex indices and texture u out.
// Channels use valid/stall; an item moves on an edge with valid high, stall low.
// Configuration: APB-style; radius at 0x0, height at 0x4, count at 0x8.
// The count is clamped to [3, min(MAX_MERIDIANS, 4096)]; an index not below
// it gives bad_index with all other fields zero.
// An item passes the queue, the bit-serial phase divider pipeline, the
// angle stage, the CORDIC, the product stage and the output register.
// Throughput: one item per cycle unless stalled; every stage is a register.
// A two-entry queue separates the accepting front end from the pipeline.
// When the receiver stalls a valid result, the whole pipeline freezes; the
// queue then fills and the input stall rises.
// Reset (synchronous, active low) empties the pipeline and loads radius 256,
// height 512 and count 32.
// Depends on crvg_pkg, crvg_front, crvg_queue and crvg_back.
`timescale 1ns / 1ps
module cylinder_ring_vertex_generator_core
    import crvg_pkg::*;
#(
    parameter int MAX_MERIDIANS = MAX_MERIDIANS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [IDX_W-1:0]        i_meridian_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [HH_W-1:0]         o_half_height,
    output logic [VTX_W-1:0]        o_upper_vertex,
    output logic [VTX_W-1:0]        o_lower_vertex,
    output logic [VTX_W-1:0]        o_next_upper_vertex,
    output logic [VTX_W-1:0]        o_next_lower_vertex,
    output logic [TEX_W-1:0]        o_tex_u,
    output logic                    o_bad_index
);
    t_job f_job, q_job;
    logic f_v, q_full, q_v, q_pop;

    assign pready = 1'b1;

    crvg_front #(.MAX_MERIDIANS(MAX_MERIDIANS)) u_front (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .i_valid, .o_stall, .i_meridian_index,
        .o_job_valid(f_v), .o_job(f_job), .i_job_full(q_full)
    );

    crvg_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_v), .i_data(f_job), .o_full(q_full),
        .o_valid(q_v), .o_data(q_job), .i_pop(q_pop)
    );

    crvg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .i_job(q_job), .o_pop(q_pop),
        .o_valid, .i_stall, .o_pos_x, .o_pos_z, .o_half_height,
        .o_upper_vertex, .o_lower_vertex, .o_next_upper_vertex,
        .o_next_lower_vertex, .o_tex_u, .o_bad_index
    );
endmodule

>>> rtl/crvg_front.sv
// Front end: register file, count clamp, index classification.
// Depends on crvg_pkg.
`timescale 1ns / 1ps
module crvg_front
    import crvg_pkg::*;
#(
    parameter int MAX_MERIDIANS = MAX_MERIDIANS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [IDX_W-1:0]    i_meridian_index,
    output logic                o_job_valid,
    output t_job                o_job,
    input  logic                i_job_full
);
    localparam logic [CNT_W:0] CMAX = (CNT_W+1)'(MAX_MERIDIANS > 4096 ? 4096 : MAX_MERIDIANS);

    logic [RAD_W-1:0] r_radius, r_height;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_eff;
    logic             wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_height <= 16'd512;
            r_count  <= 13'd32;
        end else if (wr) begin
            case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_HEIGHT: r_height <= pwdata[RAD_W-1:0];
                REG_COUNT:  r_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {16'd0, r_radius};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_COUNT:  prdata = {19'd0, r_count};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_count < 13'd3) n_eff = 13'd3;
        else if ({1'b0, r_count} > CMAX) n_eff = CMAX[CNT_W-1:0];
        else n_eff = r_count;
    end

    assign o_stall     = i_job_full;
    assign o_job_valid = i_valid && !i_job_full;
    always_comb begin
        o_job.idx    = i_meridian_index;
        o_job.cnt    = n_eff;
        o_job.bad    = {1'b0, i_meridian_index} >= n_eff;
        o_job.last   = ({1'b0, i_meridian_index} + 13'd1) == n_eff;
        o_job.radius = r_radius;
        o_job.half_h = r_height[RAD_W-1:1];
    end
endmodule

>>> rtl/crvg_queue.sv
// Two-entry queue between front and back end.
// Depends on crvg_pkg.
`timescale 1ns / 1ps
module crvg_queue
    import crvg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count corrupt");
endmodule

>>> rtl/crvg_back.sv
// Back end: phase division, CORDIC pipeline, scaling and output register.
// Depends on crvg_pkg.
`timescale 1ns / 1ps
module crvg_back
    import crvg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_job                    i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [HH_W-1:0]         o_half_height,
    output logic [VTX_W-1:0]        o_upper_vertex,
    output logic [VTX_W-1:0]        o_lower_vertex,
    output logic [VTX_W-1:0]        o_next_upper_vertex,
    output logic [VTX_W-1:0]        o_next_lower_vertex,
    output logic [TEX_W-1:0]        o_tex_u,
    output logic                    o_bad_index
);
    // Stages: DIV_ST restoring division steps (one quotient bit each), one
    // angle multiply, CORDIC_STEPS rotations, one product, one round stage.
    localparam int DIV_ST = PHASE_W;
    localparam int NST    = DIV_ST + 1 + CORDIC_STEPS + 2;

    logic adv;
    logic [NST-1:0] r_v;
    assign adv   = !o_valid || !i_stall || !r_v[NST-1];
    assign o_pop = i_valid && adv;

    // Division: phase = floor(i * 2^32 / n).
    t_job              r_dj [DIV_ST+1];
    logic [CNT_W:0]    r_rem [DIV_ST+1];
    logic [PHASE_W-1:0] r_q  [DIV_ST+1];

    always_comb begin
        r_dj[0]  = i_job;
        r_rem[0] = '0;
        r_q[0]   = '0;
    end

    // Dividend is idx followed by 32 zero bits; the remainder starts at idx.
    logic [CNT_W:0] p_rem [DIV_ST];
    logic [PHASE_W-1:0] p_q [DIV_ST];
    logic [CNT_W:0] p_init;
    assign p_init = {2'b00, i_job.idx}; // remainder before phase bits, idx < n
    genvar g;
    generate
        for (g = 0; g < DIV_ST; g++) begin : g_div
            logic [CNT_W+1:0] sh;
            logic [CNT_W:0]   base;
            assign base = (g == 0) ? p_init : r_rem[g];
            assign sh = {base, 1'b0};
            always_comb begin
                if (sh >= {1'b0, r_dj[g].cnt}) begin
                    p_rem[g] = (CNT_W+1)'(sh - {2'b00, r_dj[g].cnt});
                    p_q[g]   = {r_q[g][PHASE_W-2:0], 1'b1};
                end else begin
                    p_rem[g] = sh[CNT_W:0];
                    p_q[g]   = {r_q[g][PHASE_W-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dj[g+1]  <= r_dj[g];
                    r_rem[g+1] <= p_rem[g];
                    r_q[g+1]   <= p_q[g];
                end
            end
        end
    endgenerate

    // Angle stage.
    t_job r_aj;
    logic [1:0] r_aq;
    logic [PHASE_W-1:0] r_aph;
    logic signed [ANG_W-1:0] r_az;
    logic [61:0] zprod;
    assign zprod = 62'(r_q[DIV_ST][29:0]) * 62'(PI_HALF_Q30);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_aj  <= r_dj[DIV_ST];
            r_aq  <= r_q[DIV_ST][31:30];
            r_aph <= r_q[DIV_ST];
            r_az  <= ANG_W'(zprod[61:30]);
        end
    end

    // CORDIC pipeline.
    t_job                    r_cj [CORDIC_STEPS+1];
    logic [1:0]              r_cq [CORDIC_STEPS+1];
    logic [TEX_W-1:0]        r_ct [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] r_cx [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] r_cy [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] r_cz [CORDIC_STEPS+1];
    always_comb begin
        r_cj[0] = r_aj; r_cq[0] = r_aq; r_ct[0] = r_aph[31:16];
        r_cx[0] = ANG_W'(CORDIC_GAIN_Q30); r_cy[0] = '0; r_cz[0] = r_az;
    end
    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_cor
            logic signed [ANG_W-1:0] dx, dy, at;
            assign dx = r_cy[g] >>> g;
            assign dy = r_cx[g] >>> g;
            assign at = ANG_W'(atan_q30(g));
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_cj[g+1] <= r_cj[g];
                    r_cq[g+1] <= r_cq[g];
                    r_ct[g+1] <= r_ct[g];
                    if (!r_cz[g][ANG_W-1]) begin
                        r_cx[g+1] <= r_cx[g] - dx;
                        r_cy[g+1] <= r_cy[g] + dy;
                        r_cz[g+1] <= r_cz[g] - at;
                    end else begin
                        r_cx[g+1] <= r_cx[g] + dx;
                        r_cy[g+1] <= r_cy[g] - dy;
                        r_cz[g+1] <= r_cz[g] + at;
                    end
                end
            end
        end
    endgenerate

    // Quadrant map and multiply.
    logic signed [ANG_W-1:0] xc, xs, c, s;
    assign xc = r_cx[CORDIC_STEPS];
    assign xs = r_cy[CORDIC_STEPS];
    always_comb begin
        case (r_cq[CORDIC_STEPS])
            2'd0: begin c = xc;  s = xs;  end
            2'd1: begin c = -xs; s = xc;  end
            2'd2: begin c = -xc; s = -xs; end
            default: begin c = xs; s = -xc; end
        endcase
    end
    t_job r_mj;
    logic [TEX_W-1:0] r_mt;
    logic signed [ANG_W+RAD_W:0] r_px, r_pz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mj <= r_cj[CORDIC_STEPS];
            r_mt <= r_ct[CORDIC_STEPS];
            r_px <= $signed({1'b0, r_cj[CORDIC_STEPS].radius}) * c;
            r_pz <= $signed({1'b0, r_cj[CORDIC_STEPS].radius}) * s;
        end
    end

    function automatic logic signed [POS_W-1:0] rsat(input logic signed [ANG_W+RAD_W:0] p);
        logic signed [ANG_W+RAD_W:0] t;
        t = (p + (ANG_W+RAD_W+1)'(1 << 29)) >>> 30;
        if (t > POS_LIMIT) return POS_W'(POS_LIMIT);
        if (t < -POS_LIMIT) return -POS_W'(POS_LIMIT);
        return t[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_bad_index <= r_mj.bad;
            if (r_mj.bad) begin
                o_pos_x <= '0; o_pos_z <= '0; o_half_height <= '0;
                o_upper_vertex <= '0; o_lower_vertex <= '0;
                o_next_upper_vertex <= '0; o_next_lower_vertex <= '0;
                o_tex_u <= '0;
            end else begin
                o_pos_x <= rsat(r_px);
                o_pos_z <= rsat(r_pz);
                o_half_height <= r_mj.half_h;
                o_upper_vertex <= {r_mj.idx, 1'b0};
                o_lower_vertex <= {r_mj.idx, 1'b1};
                o_next_upper_vertex <= r_mj.last ? '0 : VTX_W'({r_mj.idx, 1'b0} + 13'd2);
                o_next_lower_vertex <= r_mj.last ? VTX_W'(1) : VTX_W'({r_mj.idx, 1'b0} + 13'd3);
                o_tex_u <= r_mt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NST-2:0], o_pop};
    end
    assign o_valid = r_v[NST-1];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result lost under stall");
    a_pop_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> adv) else $error("pop without advance");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_index |-> o_tex_u == '0) else $error("bad item not cleared");
endmodule
